// ===== design/cluster_merge_constraint_table_top_macros.svh =====
// Assertion macros for the checker of the cluster merge constraint table.
`ifndef CLUSTER_MERGE_CONSTRAINT_TABLE_TOP_MACROS_SVH
`define CLUSTER_MERGE_CONSTRAINT_TABLE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define CMCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define CMCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cmct_pkg.sv =====
// Types, constants and helpers for the cluster merge constraint table.
`default_nettype none
package cmct_pkg;

    localparam int DOCS       = 256;
    localparam int NODE_SLOTS = 512;
    localparam int NODE_AW    = 9;
    localparam int ID_W       = 9;
    localparam int CNT_W      = 9;
    localparam int COUNT_MAX  = 511;
    localparam int DIST_W     = 16;
    localparam int DIST_DEPTH = DOCS * DOCS;
    localparam int DIST_AW    = $clog2(DIST_DEPTH);
    localparam int OPND_W     = DIST_W;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_MERGE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt;
    } node_entry_t;

    typedef struct packed {
        logic               en;
        logic [NODE_AW-1:0] addr;
        node_entry_t        data;
    } node_wr_t;

    typedef struct packed {
        logic               en;
        logic [DIST_AW-1:0] addr;
        logic [DIST_W-1:0]  data;
    } dist_wr_t;

    typedef struct packed {
        logic              lt;
        logic              eq;
        logic [OPND_W:0]   sum;
    } alu_res_t;

    // Flat index of the ordered document pair (lo, hi).
    function automatic logic [DIST_AW-1:0] pair_addr(input logic [ID_W-1:0] lo,
                                                     input logic [ID_W-1:0] hi);
        return DIST_AW'(lo) * DIST_AW'(DOCS) + DIST_AW'(hi);
    endfunction

endpackage
`default_nettype wire

// ===== design/cluster_merge_constraint_table_top.sv =====
// Top level of the cluster merge constraint table: sequencer, shared unit and tables.
// One item at a time. After reset the block sweeps the distance table to zero and
// sets the leaf node entries (smallest id DOCS, count 0) with s_ready low. The time
// an item takes from acceptance to result is set by the single compare/add unit,
// which is used once per step, and by the registered reads of the node and distance
// tables. The result sits in an output register, so a result can wait for m_ready
// while the block finishes; the block accepts no new item until its result is
// handed over to that register.
`default_nettype none
module cluster_merge_constraint_table_top
    import cmct_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_command,
    input  wire logic [NODE_AW-1:0]  s_node_a,
    input  wire logic [NODE_AW-1:0]  s_node_b,
    input  wire logic [NODE_AW-1:0]  s_node_end,
    input  wire logic [DIST_W-1:0]   s_pair_distance,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_merge_allowed,
    output logic                     m_error
);

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_LOAD_CMP = 9'b000000100,
        ST_LOAD_B   = 9'b000001000,
        ST_FETCH    = 9'b000010000,
        ST_EVAL1    = 9'b000100000,
        ST_EVAL2    = 9'b001000000,
        ST_DIST     = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t              state_reg,   state_next;
    logic [DIST_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_allowed_reg, m_allowed_next;
    logic                m_error_reg, m_error_next;

    // Item and work registers (no reset needed).
    logic [1:0]          cmd_reg,     cmd_next;
    logic [NODE_AW-1:0]  a_reg,       a_next;
    logic [NODE_AW-1:0]  b_reg,       b_next;
    logic [NODE_AW-1:0]  e_reg,       e_next;
    logic [DIST_W-1:0]   dist_in_reg, dist_in_next;
    logic [ID_W-1:0]     lo_reg,      lo_next;
    logic [ID_W-1:0]     hi_reg,      hi_next;
    logic                eq_reg,      eq_next;
    logic [CNT_W:0]      sum_reg,     sum_next;
    logic                allowed_reg, allowed_next;
    logic                error_reg,   error_next;

    logic [OPND_W-1:0]   opnd_x;
    logic [OPND_W-1:0]   opnd_y;
    alu_res_t            alu_res;
    logic [CNT_W-1:0]    sat_sum;

    node_wr_t            node_wr;
    node_entry_t         node_rd_a;
    node_entry_t         node_rd_b;
    dist_wr_t            dist_wr;
    logic [DIST_W-1:0]   dist_rd;

    // ------------------------------------------------------------------
    // Shared compare/add unit and its operand select.
    // ------------------------------------------------------------------
    always_comb begin
        opnd_x = '0;
        opnd_y = '0;
        case (state_reg)
            ST_LOAD_CMP: begin
                opnd_x = OPND_W'(a_reg);
                opnd_y = OPND_W'(b_reg);
            end
            ST_EVAL1: begin
                opnd_x = OPND_W'(node_rd_a.id);
                opnd_y = OPND_W'(node_rd_b.id);
            end
            ST_EVAL2: begin
                opnd_x = OPND_W'(node_rd_a.cnt);
                opnd_y = OPND_W'(node_rd_b.cnt);
            end
            ST_DIST: begin
                opnd_x = OPND_W'(sum_reg);
                opnd_y = dist_rd;
            end
            default: begin
                opnd_x = '0;
                opnd_y = '0;
            end
        endcase
    end

    cmct_alu u_alu (
        .opnd_x (opnd_x),
        .opnd_y (opnd_y),
        .res    (alu_res)
    );

    // Count sum saturates at the field maximum.
    assign sat_sum = (alu_res.sum > (OPND_W + 1)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX)
                                                             : alu_res.sum[CNT_W-1:0];

    // ------------------------------------------------------------------
    // Tables. Node reads follow a_reg / b_reg, the distance read follows lo/hi.
    // ------------------------------------------------------------------
    cmct_node_mem u_node_mem (
        .aclk      (aclk),
        .wr        (node_wr),
        .rd_addr_a (a_reg),
        .rd_addr_b (b_reg),
        .rd_data_a (node_rd_a),
        .rd_data_b (node_rd_b)
    );

    cmct_dist_mem u_dist_mem (
        .aclk    (aclk),
        .wr      (dist_wr),
        .rd_addr (pair_addr(lo_reg, hi_reg)),
        .rd_data (dist_rd)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        m_valid_next   = m_valid_reg;
        m_allowed_next = m_allowed_reg;
        m_error_next   = m_error_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        dist_in_next   = dist_in_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        eq_next        = eq_reg;
        sum_next       = sum_reg;
        allowed_next   = allowed_reg;
        error_next     = error_reg;
        node_wr        = '0;
        dist_wr        = '0;

        // Result taken downstream.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // Sweep: distance entry to zero, node entries to count 0 with id DOCS on leaf slots, 0 above.
                dist_wr.en   = 1'b1;
                dist_wr.addr = clr_cnt_reg;
                dist_wr.data = '0;
                if (32'(clr_cnt_reg) < NODE_SLOTS) begin
                    node_wr.en       = 1'b1;
                    node_wr.addr     = clr_cnt_reg[NODE_AW-1:0];
                    node_wr.data.id  = (32'(clr_cnt_reg) < DOCS) ? ID_W'(DOCS) : '0;
                    node_wr.data.cnt = '0;
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == DIST_AW'(DIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_command;
                    a_next       = s_node_a;
                    b_next       = s_node_b;
                    e_next       = s_node_end;
                    dist_in_next = s_pair_distance;
                    allowed_next = 1'b0;
                    error_next   = 1'b0;
                    case (s_command)
                        CMD_LOAD:  state_next = ST_LOAD_CMP;
                        CMD_MERGE: state_next = ST_FETCH;
                        CMD_QUERY: state_next = ST_FETCH;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD_CMP: begin
                if (32'(a_reg) >= DOCS || 32'(b_reg) >= DOCS) begin
                    error_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    node_wr.en       = 1'b1;
                    node_wr.addr     = a_reg;
                    node_wr.data.id  = ID_W'(a_reg);
                    node_wr.data.cnt = CNT_W'(1);
                    lo_next          = alu_res.lt ? ID_W'(a_reg) : ID_W'(b_reg);
                    hi_next          = alu_res.lt ? ID_W'(b_reg) : ID_W'(a_reg);
                    state_next       = ST_LOAD_B;
                end
            end
            ST_LOAD_B: begin
                node_wr.en       = 1'b1;
                node_wr.addr     = b_reg;
                node_wr.data.id  = ID_W'(b_reg);
                node_wr.data.cnt = CNT_W'(1);
                dist_wr.en       = 1'b1;
                dist_wr.addr     = pair_addr(lo_reg, hi_reg);
                dist_wr.data     = dist_in_reg;
                state_next       = ST_DONE;
            end
            ST_FETCH: begin
                // Node reads at a_reg / b_reg land next cycle.
                state_next = ST_EVAL1;
            end
            ST_EVAL1: begin
                lo_next    = alu_res.lt ? node_rd_a.id : node_rd_b.id;
                hi_next    = alu_res.lt ? node_rd_b.id : node_rd_a.id;
                eq_next    = alu_res.eq;
                state_next = ST_EVAL2;
            end
            ST_EVAL2: begin
                sum_next = alu_res.sum[CNT_W:0];
                if (cmd_reg == CMD_MERGE) begin
                    // Both parts were read before this write, so node_end may alias.
                    node_wr.en       = 1'b1;
                    node_wr.addr     = e_reg;
                    node_wr.data.id  = lo_reg;
                    node_wr.data.cnt = sat_sum;
                    state_next       = ST_DONE;
                end else if (node_rd_a.cnt == '0 || node_rd_b.cnt == '0) begin
                    allowed_next = 1'b1;
                    state_next   = ST_DONE;
                end else if (eq_reg) begin
                    error_next = 1'b1;
                    state_next = ST_DONE;
                end else if (32'(hi_reg) >= DOCS) begin
                    // No table entry for this pair: distance counts as zero.
                    allowed_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                allowed_next = !alu_res.lt;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_allowed_next = allowed_reg;
                    m_error_next   = error_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_allowed_reg <= m_allowed_next;
        m_error_reg   <= m_error_next;
        cmd_reg       <= cmd_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        e_reg         <= e_next;
        dist_in_reg   <= dist_in_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        eq_reg        <= eq_next;
        sum_reg       <= sum_next;
        allowed_reg   <= allowed_next;
        error_reg     <= error_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_merge_allowed = m_allowed_reg;
    assign m_error         = m_error_reg;

endmodule
`default_nettype wire

// ===== design/cmct_alu.sv =====
// Shared compare and add unit used by the load compare, evaluate and distance steps of the sequencer.
`default_nettype none
module cmct_alu
    import cmct_pkg::*;
(
    input  wire logic [OPND_W-1:0] opnd_x,
    input  wire logic [OPND_W-1:0] opnd_y,
    output alu_res_t               res
);

    always_comb begin
        res.lt  = opnd_x < opnd_y;
        res.eq  = opnd_x == opnd_y;
        res.sum = {1'b0, opnd_x} + {1'b0, opnd_y};
    end

endmodule
`default_nettype wire

// ===== design/cmct_node_mem.sv =====
// Node table: smallest labeled id and labeled count per cluster node, two read ports.
`default_nettype none
module cmct_node_mem
    import cmct_pkg::*;
(
    input  wire logic               aclk,
    input  wire node_wr_t           wr,
    input  wire logic [NODE_AW-1:0] rd_addr_a,
    input  wire logic [NODE_AW-1:0] rd_addr_b,
    output node_entry_t             rd_data_a,
    output node_entry_t             rd_data_b
);

    node_entry_t mem [NODE_SLOTS];
    node_entry_t rd_a_reg;
    node_entry_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
`default_nettype wire

// ===== design/cmct_dist_mem.sv =====
// Pairwise distance table over labeled documents, one write and one read port.
`default_nettype none
module cmct_dist_mem
    import cmct_pkg::*;
(
    input  wire logic               aclk,
    input  wire dist_wr_t           wr,
    input  wire logic [DIST_AW-1:0] rd_addr,
    output logic [DIST_W-1:0]       rd_data
);

    logic [DIST_W-1:0] mem [DIST_DEPTH];
    logic [DIST_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule
`default_nettype wire

// ===== design/cmct_checker.sv =====
// Port-level checker for the cluster merge constraint table, bound to the top level.
`default_nettype none
`include "cluster_merge_constraint_table_top_macros.svh"
module cmct_checker
    import cmct_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [1:0]         s_command,
    input wire logic [NODE_AW-1:0] s_node_a,
    input wire logic [NODE_AW-1:0] s_node_b,
    input wire logic [NODE_AW-1:0] s_node_end,
    input wire logic [DIST_W-1:0]  s_pair_distance,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_merge_allowed,
    input wire logic               m_error
);

    // A stalled result holds.
    `CMCT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_merge_allowed) && $stable(m_error), "result changed while stalled")

    // An item is either allowed or in error, never both.
    `CMCT_ASSERT_IMP(a_out_excl, aclk, aresetn, m_valid, !(m_merge_allowed && m_error), "allowed and error both set")

    // One item at a time: no acceptance in the cycle after one.
    `CMCT_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "item accepted back to back")

    // Leaving reset starts the table sweep, so no item is taken.
    `CMCT_ASSERT_IMP(a_sweep_start, aclk, aresetn, $rose(aresetn), !s_ready, "ready at reset release")

endmodule

bind cluster_merge_constraint_table_top cmct_checker u_cmct_checker (.*);
`default_nettype wire
